>>> hdl/iol_pkg.sv
package iol_pkg;

    // operation kinds
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_INSERT     = 3'd4;
    localparam logic [2:0] KIND_REMOVE     = 3'd5;
    localparam logic [2:0] KIND_FIND       = 3'd6;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch the input item and decode it
        logic step;       // issue one read of the walk
        logic commit;     // place the new value on insert, adjust the count
        logic rd_front;   // read address 0
        logic cap_front;  // capture the front value
        logic emit;       // load the output register
    } iol_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic do_ins;
        logic do_rem;
        logic do_find;
        logic walk_done;
        logic scan_done;
    } iol_stat_t;

endpackage

>>> hdl/iol_ram.sv
module iol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> hdl/iol_ctrl.sv
module iol_ctrl
    import iol_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  iol_stat_t stat,
    output iol_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECIDE   = 8'b0000_0010,
        S_SHIFT    = 8'b0000_0100,
        S_SCAN     = 8'b0000_1000,
        S_COMMIT   = 8'b0001_0000,
        S_RD_FRONT = 8'b0010_0000,
        S_RD_BACK  = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.do_ins || stat.do_rem)
                begin
                    state_next = S_SHIFT;
                end
                else if (stat.do_find)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_RD_FRONT;
                end
            end
            S_SHIFT:
            begin
                cmd.step = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_RD_FRONT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RD_FRONT;
            end
            S_RD_FRONT:
            begin
                cmd.rd_front = 1'b1;
                state_next   = S_RD_BACK;
            end
            S_RD_BACK:
            begin
                cmd.cap_front = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> hdl/iol_dp.sv
module iol_dp
    import iol_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IN_W       = 40,
    parameter int OUT_W      = 80
) (
    input  logic             clk,
    input  logic             rst_n,
    input  iol_cmd_t         cmd,
    output iol_stat_t        stat,
    input  logic [IN_W-1:0]  s_tdata,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int PACK_W = STATUS_W + 2 * CW + 1 + 2 * DATA_WIDTH;

    // input fields
    logic [KIND_W-1:0]     in_kind;
    logic [CW-1:0]         in_pos;
    logic [DATA_WIDTH-1:0] in_value;

    assign in_kind  = s_tdata[KIND_W-1:0];
    assign in_pos   = s_tdata[KIND_W+CW-1:KIND_W];
    assign in_value = s_tdata[KIND_W+CW+DATA_WIDTH-1:KIND_W+CW];

    // control state
    logic [CW-1:0] count_reg,  count_next;
    logic [CW-1:0] left_reg,   left_next;
    logic          pend_reg,   pend_next;
    logic          hit_reg,    hit_next;
    logic          do_ins_reg, do_ins_next;
    logic          do_rem_reg, do_rem_next;
    logic          do_find_reg, do_find_next;

    // payload
    logic [CW-1:0]         ptr_reg,      ptr_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    logic [AW-1:0]         pos_reg,      pos_next;
    logic [DATA_WIDTH-1:0] value_reg,    value_next;
    logic [STATUS_W-1:0]   status_reg,   status_next;
    logic [CW-1:0]         found_reg,    found_next;
    logic [DATA_WIDTH-1:0] front_reg,    front_next;
    logic [PACK_W-1:0]     out_reg,      out_next;

    // decode
    logic                is_ins;
    logic                is_rem;
    logic                is_find;
    logic [CW-1:0]       eff_pos;
    logic [STATUS_W-1:0] dec_status;

    // ram side
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [CW-1:0]         last_idx;
    logic [CW-1:0]         walk_dest;
    logic                  ends_valid;

    always_comb
    begin
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        is_find = 1'b0;
        eff_pos = '0;
        case (in_kind)
            KIND_PUSH_FRONT:
            begin
                is_ins = 1'b1;
            end
            KIND_PUSH_BACK:
            begin
                is_ins  = 1'b1;
                eff_pos = count_reg;
            end
            KIND_POP_FRONT:
            begin
                is_rem = 1'b1;
            end
            KIND_POP_BACK:
            begin
                is_rem  = 1'b1;
                // empty list keeps position 0 so the range check rejects it
                eff_pos = (count_reg == '0) ? '0 : count_reg - CW'(1);
            end
            KIND_INSERT:
            begin
                is_ins  = 1'b1;
                eff_pos = in_pos;
            end
            KIND_REMOVE:
            begin
                is_rem  = 1'b1;
                eff_pos = in_pos;
            end
            KIND_FIND:
            begin
                is_find = 1'b1;
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        dec_status = ST_DONE;
        if (is_ins)
        begin
            if (eff_pos > count_reg)
            begin
                dec_status = ST_RANGE;
            end
            else if (count_reg >= CW'(DEPTH))
            begin
                dec_status = ST_FULL;
            end
        end
        else if (is_rem)
        begin
            if (eff_pos >= count_reg)
            begin
                dec_status = ST_RANGE;
            end
        end
    end

    assign last_idx  = count_reg - CW'(1);
    assign walk_dest = do_ins_reg ? ptr_reg + CW'(1) :
                       do_rem_reg ? ptr_reg - CW'(1) : ptr_reg;

    always_comb
    begin
        count_next    = count_reg;
        left_next     = left_reg;
        pend_next     = 1'b0;
        hit_next      = hit_reg;
        do_ins_next   = do_ins_reg;
        do_rem_next   = do_rem_reg;
        do_find_next  = do_find_reg;
        ptr_next      = ptr_reg;
        pend_idx_next = pend_idx_reg;
        pos_next      = pos_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        front_next    = front_reg;
        out_next      = out_reg;

        if (cmd.load)
        begin
            do_ins_next  = is_ins && (dec_status == ST_DONE);
            do_rem_next  = is_rem && (dec_status == ST_DONE);
            do_find_next = is_find;
            hit_next     = 1'b0;
            status_next  = dec_status;
            found_next   = is_find ? count_reg : '0;
            pos_next     = eff_pos[AW-1:0];
            value_next   = in_value;
            left_next    = '0;
            ptr_next     = '0;
            if (dec_status == ST_DONE)
            begin
                if (is_ins)
                begin
                    // walk down from the back, each entry moves up one
                    ptr_next  = count_reg - CW'(1);
                    left_next = count_reg - eff_pos;
                end
                else if (is_rem)
                begin
                    // walk up from above the hole, each entry moves down one
                    ptr_next  = eff_pos + CW'(1);
                    left_next = count_reg - eff_pos - CW'(1);
                end
                else if (is_find)
                begin
                    left_next = count_reg;
                end
            end
        end

        if (cmd.step && (left_reg != '0))
        begin
            pend_next     = 1'b1;
            pend_idx_next = walk_dest[AW-1:0];
            left_next     = left_reg - CW'(1);
            ptr_next      = do_ins_reg ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
        end

        // first match wins
        if (pend_reg && do_find_reg && !hit_reg && (ram_rdata == value_reg))
        begin
            hit_next   = 1'b1;
            found_next = CW'(pend_idx_reg);
        end

        if (cmd.commit)
        begin
            if (do_ins_reg)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (do_rem_reg)
            begin
                count_next = count_reg - CW'(1);
            end
        end

        if (cmd.cap_front)
        begin
            front_next = ram_rdata;
        end

        if (cmd.emit)
        begin
            out_next = {ends_valid ? ram_rdata : '0,
                        ends_valid ? front_reg : '0,
                        ends_valid,
                        count_reg,
                        found_reg,
                        status_reg};
        end
    end

    assign ends_valid = (count_reg != '0);

    assign ram_we    = (pend_reg && (do_ins_reg || do_rem_reg)) ||
                       (cmd.commit && do_ins_reg);
    assign ram_waddr = cmd.commit ? pos_reg : pend_idx_reg;
    assign ram_wdata = cmd.commit ? value_reg : ram_rdata;
    assign ram_raddr = cmd.step     ? ptr_reg[AW-1:0] :
                       cmd.rd_front ? '0 : last_idx[AW-1:0];

    iol_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            do_ins_reg  <= 1'b0;
            do_rem_reg  <= 1'b0;
            do_find_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            do_ins_reg  <= do_ins_next;
            do_rem_reg  <= do_rem_next;
            do_find_reg <= do_find_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        front_reg    <= front_next;
        out_reg      <= out_next;
    end

    assign stat.do_ins    = do_ins_reg;
    assign stat.do_rem    = do_rem_reg;
    assign stat.do_find   = do_find_reg;
    assign stat.walk_done = (left_reg == '0) && !pend_reg;
    assign stat.scan_done = hit_reg || ((left_reg == '0) && !pend_reg);

    assign m_tdata = OUT_W'(out_reg);

endmodule

>>> hdl/indexed_ordered_list.sv
// channel | dir | tdata fields, lowest bit first
// s_axis  | in  | kind[3], position[clog2(DEPTH+1)], value[DATA_WIDTH]
// m_axis  | out | status[2], found_at, entry_count, ends_valid[1], front_value, back_value
//
// one item at a time, paced by the single ram read port: each item passes idle, decide,
// read front, read back and emit; a successful insert/remove first walks the moves
// (count-pos for insert, count-pos-1 for remove), then commits; find first scans
// the reads up to the first match (count if absent)
// asynchronous active-low reset empties the list; ram contents are not cleared
// a held result stalls only the emit step; the next item can be taken while it is held
module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int IN_W  = ((KIND_W + CW + DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((STATUS_W + 2 * CW + 1 + 2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // kind, position, value
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, found_at, entry_count, ends_valid, front_value, back_value
    output logic [OUT_W-1:0] m_tdata
);

    iol_cmd_t  cmd;
    iol_stat_t stat;

    iol_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iol_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

    logic [STATUS_W-1:0] out_status;
    logic [CW-1:0]       out_count;
    logic                out_ends_valid;

    assign out_status     = m_tdata[STATUS_W-1:0];
    assign out_count      = m_tdata[STATUS_W+2*CW-1:STATUS_W+CW];
    assign out_ends_valid = m_tdata[STATUS_W+2*CW];

    // one item in flight: no second accept right after the first
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_ends_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_ends_valid == (out_count != '0)))
        else $error("ends_valid disagrees with entry_count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_status == ST_FULL)) |-> (out_count == CW'(DEPTH)))
        else $error("full status with list not full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_count <= CW'(DEPTH)))
        else $error("entry_count beyond depth");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_status == ST_DONE) || (out_status == ST_RANGE) ||
                      (out_status == ST_FULL)))
        else $error("undefined status code");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import iol_pkg::*;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 80;

    // code outside the defined kinds, block reports state and does nothing
    localparam logic [2:0] KIND_NONE = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [4:0]            found_at;
        logic [4:0]            entry_count;
        logic                  ends_valid;
        logic [DATA_WIDTH-1:0] front_value;
        logic [DATA_WIDTH-1:0] back_value;
    } list_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // kind[2:0], position[7:3], value[39:8]
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // status[1:0], found_at[6:2], entry_count[11:7], ends_valid[12],
    // front_value[44:13], back_value[76:45]
    logic [OUT_W-1:0] m_tdata;

    logic [DATA_WIDTH-1:0] held_values[$];
    list_result_t          pending_results[$];
    int                    error_count = 0;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;

    indexed_ordered_list #(
        .DEPTH(DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [STATUS_W-1:0] place_value(input int at,
                                                         input logic [DATA_WIDTH-1:0] val);
        if (at > held_values.size())
            return ST_RANGE;
        if (held_values.size() >= DEPTH)
            return ST_FULL;
        held_values.insert(at, val);
        return ST_DONE;
    endfunction

    function automatic logic [STATUS_W-1:0] take_value(input int at);
        if (at >= held_values.size())
            return ST_RANGE;
        held_values.delete(at);
        return ST_DONE;
    endfunction

    // updates the list copy and queues the result the block must return
    function automatic void apply_list_op(input logic [2:0] kind, input logic [4:0] pos,
                                          input logic [DATA_WIDTH-1:0] val);
        list_result_t r;
        int           n;
        r.status   = ST_DONE;
        r.found_at = '0;
        case (kind)
            KIND_PUSH_FRONT: r.status = place_value(0, val);
            KIND_PUSH_BACK:  r.status = place_value(held_values.size(), val);
            KIND_POP_FRONT:  r.status = take_value(0);
            KIND_POP_BACK:
            begin
                if (held_values.size() == 0)
                    r.status = ST_RANGE;
                else
                    r.status = take_value(held_values.size() - 1);
            end
            KIND_INSERT:     r.status = place_value(int'(pos), val);
            KIND_REMOVE:     r.status = take_value(int'(pos));
            KIND_FIND:
            begin
                r.found_at = 5'(held_values.size());
                for (int i = 0; i < held_values.size(); i++)
                begin
                    if (held_values[i] == val)
                    begin
                        r.found_at = 5'(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        n = held_values.size();
        r.entry_count = 5'(n);
        r.ends_valid  = (n > 0);
        r.front_value = (n > 0) ? held_values[0] : '0;
        r.back_value  = (n > 0) ? held_values[n-1] : '0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic send_op(input logic [2:0] kind, input logic [4:0] pos,
                           input logic [DATA_WIDTH-1:0] val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos, kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_list_op(kind, pos, val);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] exp_val,
                               input logic [DATA_WIDTH-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name,
                     exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %0h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                check_field("status", 32'(exp_r.status), 32'(m_tdata[1:0]));
                check_field("found_at", 32'(exp_r.found_at), 32'(m_tdata[6:2]));
                check_field("entry_count", 32'(exp_r.entry_count), 32'(m_tdata[11:7]));
                check_field("ends_valid", 32'(exp_r.ends_valid), 32'(m_tdata[12]));
                check_field("front_value", exp_r.front_value, m_tdata[44:13]);
                check_field("back_value", exp_r.back_value, m_tdata[76:45]);
            end
        end
    end

    // extremes and a few repeated small values so finds see duplicates
    function automatic logic [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DATA_WIDTH'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_op(KIND_POP_FRONT, 5'd0, 32'h1);
        send_op(KIND_POP_BACK, 5'd0, 32'h2);
        send_op(KIND_REMOVE, 5'd0, 32'h3);
        send_op(KIND_FIND, 5'd0, 32'h0);
        send_op(KIND_INSERT, 5'd1, 32'h4);
        send_op(KIND_NONE, 5'd31, 32'hffff_ffff);
    endtask

    task automatic test_basic_ops();
        send_op(KIND_INSERT, 5'd0, 32'h0000_0005);
        send_op(KIND_PUSH_FRONT, 5'd0, 32'h0000_0000);
        send_op(KIND_PUSH_BACK, 5'd0, 32'hffff_ffff);
        send_op(KIND_INSERT, 5'd3, 32'h8000_0001);
        send_op(KIND_INSERT, 5'd2, 32'h0000_0005);
        send_op(KIND_INSERT, 5'd7, 32'h1234_5678);
        send_op(KIND_FIND, 5'd0, 32'h0000_0005);
        send_op(KIND_FIND, 5'd0, 32'hffff_ffff);
        send_op(KIND_FIND, 5'd0, 32'hdead_beef);
        send_op(KIND_REMOVE, 5'd5, 32'h0);
        send_op(KIND_REMOVE, 5'd2, 32'h0);
        send_op(KIND_NONE, 5'd16, 32'h0);
        send_op(KIND_POP_BACK, 5'd0, 32'h0);
        send_op(KIND_POP_FRONT, 5'd0, 32'h0);
        send_op(KIND_REMOVE, 5'd1, 32'h0);
        send_op(KIND_REMOVE, 5'd0, 32'h0);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i % 2 == 0)
                send_op(KIND_PUSH_BACK, 5'd0, 32'h100 + i);
            else
                send_op(KIND_PUSH_FRONT, 5'd0, 32'h100 + i);
        end
        send_op(KIND_PUSH_BACK, 5'd0, 32'hffff_ffff);
        send_op(KIND_PUSH_FRONT, 5'd0, 32'h0);
        send_op(KIND_INSERT, 5'd16, 32'h5a5a_5a5a);
        send_op(KIND_INSERT, 5'd3, 32'ha5a5_a5a5);
        send_op(KIND_FIND, 5'd0, 32'h10e);
        send_op(KIND_FIND, 5'd0, 32'h10f);
        send_op(KIND_FIND, 5'd0, 32'h0);
        send_op(KIND_REMOVE, 5'd16, 32'h0);
        send_op(KIND_REMOVE, 5'd15, 32'h0);
        send_op(KIND_INSERT, 5'd15, 32'h7777_7777);
        while (held_values.size() > 0)
            send_op(KIND_REMOVE, 5'($urandom_range(held_values.size() - 1)), 32'h0);
    endtask

    task automatic test_random_ops(input int n_items, input int tx_pct, input int rx_pct);
        logic [2:0]            kind;
        logic [4:0]            pos;
        logic [DATA_WIDTH-1:0] val;
        int                    r;
        int                    n;
        bit                    growing;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        growing = 1'b1;
        for (int k = 0; k < n_items; k++)
        begin
            n = held_values.size();
            // drift between filling and emptying so both ends get exercised
            if (n == DEPTH || $urandom_range(29) == 0)
                growing = 1'b0;
            if (n == 0 || $urandom_range(29) == 0)
                growing = 1'b1;
            r = $urandom_range(99);
            if (r >= 85)
                kind = KIND_FIND;
            else if (growing)
                kind = (r < 20) ? KIND_PUSH_FRONT : (r < 40) ? KIND_PUSH_BACK :
                       (r < 58) ? KIND_INSERT : (r < 65) ? KIND_POP_FRONT :
                       (r < 72) ? KIND_POP_BACK : KIND_REMOVE;
            else
                kind = (r < 7) ? KIND_PUSH_FRONT : (r < 14) ? KIND_PUSH_BACK :
                       (r < 27) ? KIND_INSERT : (r < 45) ? KIND_POP_FRONT :
                       (r < 63) ? KIND_POP_BACK : KIND_REMOVE;
            if ($urandom_range(9) == 0)
                pos = 5'($urandom_range(DEPTH));
            else if (kind == KIND_REMOVE)
                pos = 5'($urandom_range((n > 0) ? n - 1 : 0));
            else
                pos = 5'($urandom_range(n));
            if (kind == KIND_FIND && n > 0 && $urandom_range(1))
                val = held_values[$urandom_range(n - 1)];
            else
                val = pick_value();
            send_op(kind, pos, val);
            if (k == n_items / 2)
                wait_all_results();
        end
        wait_all_results();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random_ops(340, 15, 82);
        test_random_ops(340, 82, 15);
        test_random_ops(340, 0, 0);
        wait_all_results();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> indexed_ordered_list.f
hdl/iol_pkg.sv
hdl/iol_ram.sv
hdl/iol_ctrl.sv
hdl/iol_dp.sv
hdl/indexed_ordered_list.sv
tb/tb.sv
